[design/ihrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihrc_pkg
// Shared constants, result codes, the frame summary struct and the
// ones-complement fold used by the IPv4 header receive check.
// ----------------------------------------------------------------------------
package ihrc_pkg;

   localparam int LINK_HEADER_BYTES = 14;
   localparam int NET_HEADER_BYTES  = 20;
   localparam int POS_W             = 6;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [7:0] PROTO_ICMP  = 8'd1;
   localparam logic [3:0] IP_VERSION  = 4'd4;
   localparam logic [3:0] IP_IHL      = 4'd5;
   localparam logic [15:0] CSUM_GOOD  = 16'hFFFF;

   // byte offsets inside the IPv4 header
   localparam logic [4:0] HDR_VER_LEN   = 5'd0;
   localparam logic [4:0] HDR_PROTO     = 5'd9;
   localparam logic [4:0] HDR_CSUM_HI   = 5'd10;
   localparam logic [4:0] HDR_CSUM_LO   = 5'd11;
   localparam logic [4:0] HDR_SRC_FIRST = 5'd12;
   localparam logic [4:0] HDR_SRC_LAST  = 5'd15;
   localparam logic [4:0] HDR_DST_FIRST = 5'd16;
   localparam logic [4:0] HDR_DST_LAST  = 5'd19;

   // verdict codes
   localparam logic [2:0] VERDICT_SHORT     = 3'd0;
   localparam logic [2:0] VERDICT_BAD_HDR   = 3'd1;
   localparam logic [2:0] VERDICT_BAD_CSUM  = 3'd2;
   localparam logic [2:0] VERDICT_NOT_LOCAL = 3'd3;
   localparam logic [2:0] VERDICT_BAD_PROTO = 3'd4;
   localparam logic [2:0] VERDICT_ICMP      = 3'd5;

   // CSR map: one register, local_address, at byte address 0
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_LOCAL_ADDRESS = 1'b0;

   typedef struct packed {
      logic        too_short;
      logic [7:0]  ver_len;
      logic [16:0] sum;
      logic [15:0] csum;
      logic [31:0] dst;
      logic [31:0] src;
      logic [7:0]  proto;
   } frame_type;

   // two end-around folds of a 16-bit ones-complement sum
   function automatic logic [16:0] fold16(input logic [17:0] s);
      logic [16:0] f1;
      logic [16:0] f2;
      f1 = 17'(s[15:0]) + 17'(s[17:16]);
      f2 = 17'(f1[15:0]) + 17'(f1[16]);
      return f2;
   endfunction

endpackage

[design/ipv4_header_receive_check.sv]
`timescale 1ns / 1ps
// Takes one frame byte per cycle; a byte beat stalls only while a finished frame
// waits in the frame register behind a stalled verdict beat.
// After the last-byte beat is accepted, the frame summary passes the frame register,
// then the result register, before the verdict beat is valid.
// Capture/fold stage throughput: one beat per clock, but for the stall named above.
// Synchronous active-high reset clears frame state, sender address and local address.
// ----------------------------------------------------------------------------
// ipv4_header_receive_check
// IPv4 header check on a byte stream: length, version/IHL, header checksum,
// destination and protocol, giving one verdict per frame.
// ----------------------------------------------------------------------------
module ipv4_header_receive_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_frame_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_verdict,
   output logic [31:0]                     rsp_sender_address,
   output logic [7:0]                      rsp_protocol_number,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ihrc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic                fin_valid;
   logic                fin_take;
   ihrc_pkg::frame_type fin;
   logic [31:0]         local_address;

   ihrc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .local_address (local_address)
   );

   ihrc_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_frame_byte (req_frame_byte),
      .req_last_byte  (req_last_byte),
      .fin_valid      (fin_valid),
      .fin            (fin),
      .fin_take       (fin_take)
   );

   ihrc_verdict u_verdict (
      .clock               (clock),
      .reset               (reset),
      .fin_valid           (fin_valid),
      .fin                 (fin),
      .fin_take            (fin_take),
      .local_address       (local_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_verdict         (rsp_verdict),
      .rsp_sender_address  (rsp_sender_address),
      .rsp_protocol_number (rsp_protocol_number)
   );

endmodule

[design/ihrc_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihrc_csr
// APB register block holding the local IPv4 address.
// ----------------------------------------------------------------------------
module ihrc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ihrc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output logic [31:0]                     local_address
);

   logic [31:0] local_addr_ff;
   logic        reg_hit;

   assign reg_hit    = (csr_paddr[2] == ihrc_pkg::REG_LOCAL_ADDRESS);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? local_addr_ff : 32'd0;
   assign local_address = local_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= 32'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         local_addr_ff <= csr_pwdata;
      end
   end

endmodule

[design/ihrc_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihrc_accum
// Per-beat stage: counts frame bytes, captures header fields and folds the
// header words. On the last beat it hands the frame summary to the verdict
// stage and clears for the next frame.
// ----------------------------------------------------------------------------
module ihrc_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_frame_byte,
   input  logic                  req_last_byte,
   output logic                  fin_valid,
   output ihrc_pkg::frame_type   fin,
   input  logic                  fin_take
);

   logic [ihrc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [16:0] sum_ff, sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic [7:0]  ver_ff, ver_in;
   logic [15:0] csum_ff, csum_in;
   logic [31:0] dst_ff, dst_in;
   logic [31:0] src_ff, src_in;
   logic [7:0]  proto_ff, proto_in;
   logic        fin_valid_ff;
   ihrc_pkg::frame_type fin_ff;

   logic                       accept;
   logic                       in_hdr;
   logic [ihrc_pkg::POS_W-1:0] hdr_off;
   logic [4:0]                 hdr_idx;
   logic                       too_short;

   assign req_ready = !fin_valid_ff || fin_take;
   assign accept    = req_valid && req_ready;
   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

   assign in_hdr  = (pos_ff >= ihrc_pkg::POS_W'(ihrc_pkg::LINK_HEADER_BYTES)) &&
                    (pos_ff <  ihrc_pkg::POS_W'(ihrc_pkg::LINK_HEADER_BYTES +
                                                ihrc_pkg::NET_HEADER_BYTES));
   assign hdr_off = pos_ff - ihrc_pkg::POS_W'(ihrc_pkg::LINK_HEADER_BYTES);
   assign hdr_idx = hdr_off[4:0];
   // count after this byte is below the full link + IPv4 header length
   assign too_short = ((ihrc_pkg::POS_W+1)'(pos_ff) + 1'b1) <
                      (ihrc_pkg::POS_W+1)'(ihrc_pkg::LINK_HEADER_BYTES +
                                           ihrc_pkg::NET_HEADER_BYTES);

   always_comb begin
      sum_in   = sum_ff;
      hold_in  = hold_ff;
      ver_in   = ver_ff;
      csum_in  = csum_ff;
      dst_in   = dst_ff;
      src_in   = src_ff;
      proto_in = proto_ff;
      if (in_hdr) begin
         priority if (hdr_idx == ihrc_pkg::HDR_VER_LEN) begin
            ver_in = req_frame_byte;
         end else if (hdr_idx == ihrc_pkg::HDR_PROTO) begin
            proto_in = req_frame_byte;
         end else if (hdr_idx == ihrc_pkg::HDR_CSUM_HI ||
                      hdr_idx == ihrc_pkg::HDR_CSUM_LO) begin
            csum_in = {csum_ff[7:0], req_frame_byte};
         end else if (hdr_idx >= ihrc_pkg::HDR_SRC_FIRST &&
                      hdr_idx <= ihrc_pkg::HDR_SRC_LAST) begin
            src_in = {src_ff[23:0], req_frame_byte};
         end else if (hdr_idx >= ihrc_pkg::HDR_DST_FIRST &&
                      hdr_idx <= ihrc_pkg::HDR_DST_LAST) begin
            dst_in = {dst_ff[23:0], req_frame_byte};
         end else begin
            ver_in = ver_ff;
         end
         // even offset opens a word; odd closes it, checksum word skipped
         if (!hdr_idx[0]) begin
            hold_in = req_frame_byte;
         end else if (hdr_idx != ihrc_pkg::HDR_CSUM_LO) begin
            sum_in = ihrc_pkg::fold16(18'(sum_ff) + 18'({hold_ff, req_frame_byte}));
         end
      end
      pos_in = (pos_ff == ihrc_pkg::POS_MAX) ? pos_ff : pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         hold_ff  <= '0;
         ver_ff   <= '0;
         csum_ff  <= '0;
         dst_ff   <= '0;
         src_ff   <= '0;
         proto_ff <= '0;
      end else if (accept) begin
         if (req_last_byte) begin
            pos_ff   <= '0;
            sum_ff   <= '0;
            hold_ff  <= '0;
            ver_ff   <= '0;
            csum_ff  <= '0;
            dst_ff   <= '0;
            src_ff   <= '0;
            proto_ff <= '0;
         end else begin
            pos_ff   <= pos_in;
            sum_ff   <= sum_in;
            hold_ff  <= hold_in;
            ver_ff   <= ver_in;
            csum_ff  <= csum_in;
            dst_ff   <= dst_in;
            src_ff   <= src_in;
            proto_ff <= proto_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (accept && req_last_byte) begin
         fin_valid_ff <= 1'b1;
      end else if (fin_take) begin
         fin_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         fin_ff.too_short <= too_short;
         fin_ff.ver_len   <= ver_in;
         fin_ff.sum       <= sum_in;
         fin_ff.csum      <= csum_in;
         fin_ff.dst       <= dst_in;
         fin_ff.src       <= src_in;
         fin_ff.proto     <= proto_in;
      end
   end

endmodule

[design/ihrc_verdict.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihrc_verdict
// Result stage: ranks the frame checks into one verdict, keeps the sender
// address of the last frame addressed here, and holds the result beat.
// ----------------------------------------------------------------------------
module ihrc_verdict (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fin_valid,
   input  ihrc_pkg::frame_type  fin,
   output logic                 fin_take,
   input  logic [31:0]          local_address,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_verdict,
   output logic [31:0]          rsp_sender_address,
   output logic [7:0]           rsp_protocol_number
);

   logic        rsp_valid_ff;
   logic [2:0]  verdict_ff, verdict_in;
   logic [31:0] sender_ff, sender_in;
   logic [7:0]  proto_ff;

   logic [16:0] csum_fold;
   logic [15:0] calc;

   assign fin_take = fin_valid && (!rsp_valid_ff || rsp_ready);
   assign calc      = ~fin.sum[15:0];
   assign csum_fold = ihrc_pkg::fold16(18'(fin.csum) + 18'(calc));

   always_comb begin
      sender_in = sender_ff;
      priority if (fin.too_short) begin
         verdict_in = ihrc_pkg::VERDICT_SHORT;
      end else if (fin.ver_len[7:4] != ihrc_pkg::IP_VERSION ||
                   fin.ver_len[3:0] != ihrc_pkg::IP_IHL) begin
         verdict_in = ihrc_pkg::VERDICT_BAD_HDR;
      end else if (csum_fold[15:0] != ihrc_pkg::CSUM_GOOD) begin
         verdict_in = ihrc_pkg::VERDICT_BAD_CSUM;
      end else if (fin.dst != local_address) begin
         verdict_in = ihrc_pkg::VERDICT_NOT_LOCAL;
      end else begin
         sender_in  = fin.src;
         verdict_in = (fin.proto == ihrc_pkg::PROTO_ICMP) ? ihrc_pkg::VERDICT_ICMP
                                                          : ihrc_pkg::VERDICT_BAD_PROTO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sender_ff    <= 32'd0;
      end else if (fin_take) begin
         rsp_valid_ff <= 1'b1;
         sender_ff    <= sender_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_take) begin
         verdict_ff <= verdict_in;
         proto_ff   <= fin.proto;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = verdict_ff;
   assign rsp_sender_address  = sender_ff;
   assign rsp_protocol_number = proto_ff;

endmodule

[design/ihrc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihrc_checker
// Port-level checks for the IPv4 header receive check, bound to the top.
// ----------------------------------------------------------------------------
module ihrc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [2:0]                      rsp_verdict,
   input logic [31:0]                     rsp_sender_address,
   input logic [7:0]                      rsp_protocol_number,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [ihrc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [31:0]                     csr_pwdata,
   input logic [31:0]                     csr_prdata
);

   // a stalled result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict) &&
      $stable(rsp_sender_address) && $stable(rsp_protocol_number))
      else $error("result beat changed while stalled");

   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict <= ihrc_pkg::VERDICT_ICMP)
      else $error("verdict code out of range");

   // sender address only moves on a new beat for a frame addressed here
   a_sender_update: assert property (@(posedge clock) disable iff (reset)
      !$stable(rsp_sender_address) |-> rsp_valid &&
      (rsp_verdict == ihrc_pkg::VERDICT_BAD_PROTO ||
       rsp_verdict == ihrc_pkg::VERDICT_ICMP))
      else $error("sender address changed without an addressed frame");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite &&
      csr_paddr[2] == ihrc_pkg::REG_LOCAL_ADDRESS
      |=> csr_paddr[2] != ihrc_pkg::REG_LOCAL_ADDRESS ||
          csr_prdata == $past(csr_pwdata))
      else $error("local address readback mismatch");

   // input only backs up behind a stalled result beat
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a stalled result beat");

endmodule

bind ipv4_header_receive_check ihrc_checker u_ihrc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_verdict         (rsp_verdict),
   .rsp_sender_address  (rsp_sender_address),
   .rsp_protocol_number (rsp_protocol_number),
   .csr_psel            (csr_psel),
   .csr_penable         (csr_penable),
   .csr_pwrite          (csr_pwrite),
   .csr_paddr           (csr_paddr),
   .csr_pwdata          (csr_pwdata),
   .csr_prdata          (csr_prdata)
);
